// ===== rtl/u8s_pkg.sv =====
package u8s_pkg;

   // lead and continuation byte limits
   localparam logic [7:0] ASCII_MAX   = 8'h7F;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD2_MAX   = 8'hDF;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD3_MAX   = 8'hEF;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;
   localparam logic [1:0] CONT_TAG    = 2'b10;

   // leads with a narrowed second byte range
   localparam logic [7:0] LEAD_E0     = 8'hE0;
   localparam logic [7:0] LEAD_ED     = 8'hED;
   localparam logic [7:0] LEAD_F0     = 8'hF0;
   localparam logic [7:0] LEAD_F4     = 8'hF4;
   localparam logic [7:0] E0_SEC_MIN  = 8'hA0;
   localparam logic [7:0] ED_SEC_LIM  = 8'hA0;
   localparam logic [7:0] F0_SEC_MIN  = 8'h90;
   localparam logic [7:0] F4_SEC_MAX  = 8'h8F;

   // replacement character EF BF BD
   localparam logic [7:0] REPL_B0     = 8'hEF;
   localparam logic [7:0] REPL_B1     = 8'hBF;
   localparam logic [7:0] REPL_B2     = 8'hBD;
   localparam logic [2:0] REPL_LEN    = 3'd3;

   // action codes
   localparam logic       ACT_APPEND  = 1'b0;
   localparam logic       ACT_FLUSH   = 1'b1;

   // sequence length from the lead byte, zero for a bad lead
   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      logic [2:0] len;
      len = 3'd0;
      if (lead <= ASCII_MAX) begin
         len = 3'd1;
      end else if (lead >= LEAD2_MIN && lead <= LEAD2_MAX) begin
         len = 3'd2;
      end else if (lead >= LEAD3_MIN && lead <= LEAD3_MAX) begin
         len = 3'd3;
      end else if (lead >= LEAD4_MIN && lead <= LEAD4_MAX) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // byte k of the replacement character
   function automatic logic [7:0] repl_byte(input logic [1:0] k);
      logic [7:0] b;
      case (k)
         2'd0:    b = REPL_B0;
         2'd1:    b = REPL_B1;
         default: b = REPL_B2;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/utf8_stream_sanitizer.sv =====
// an item's time grows with the sequences scanned by the per-sequence check step and the
// bytes emitted by the one-byte-per-cycle emit loop, which waits while the output stalls
// one item at a time: req_ready is high only between items
// reset: synchronous, active high; clears the held count, sequencer and output valid
module utf8_stream_sanitizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT,
      S_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  buf_ff [4];
   logic [7:0]  buf_in [4];
   logic [2:0]  cnt_ff, cnt_in;
   logic        flush_ff, flush_in;
   logic        drain_ff, drain_in;
   logic        repl_ff, repl_in;
   logic [2:0]  emit_len_ff, emit_len_in;
   logic [1:0]  emit_k_ff, emit_k_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_byte_ff, pend_byte_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        out_free;
   logic        can_push;
   logic [2:0]  lead_len;
   logic        seq_good;
   logic [7:0]  new_byte;
   logic        emit_end;

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   // output register can take a word this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_push = !pend_valid_ff || out_free;

   // check unit on the sequence at the head of the window
   always_comb begin
      lead_len = u8s_pkg::seq_len(buf_ff[0]);
      seq_good = 1'b1;
      if (lead_len >= 3'd2 && buf_ff[1][7:6] != u8s_pkg::CONT_TAG) begin
         seq_good = 1'b0;
      end
      if (lead_len >= 3'd3 && buf_ff[2][7:6] != u8s_pkg::CONT_TAG) begin
         seq_good = 1'b0;
      end
      if (lead_len == 3'd4 && buf_ff[3][7:6] != u8s_pkg::CONT_TAG) begin
         seq_good = 1'b0;
      end
      if (buf_ff[0] == u8s_pkg::LEAD_E0 && buf_ff[1] < u8s_pkg::E0_SEC_MIN) begin
         seq_good = 1'b0;
      end
      if (buf_ff[0] == u8s_pkg::LEAD_ED && buf_ff[1] >= u8s_pkg::ED_SEC_LIM) begin
         seq_good = 1'b0;
      end
      if (buf_ff[0] == u8s_pkg::LEAD_F0 && buf_ff[1] < u8s_pkg::F0_SEC_MIN) begin
         seq_good = 1'b0;
      end
      if (buf_ff[0] == u8s_pkg::LEAD_F4 && buf_ff[1] > u8s_pkg::F4_SEC_MAX) begin
         seq_good = 1'b0;
      end
   end

   // byte produced by the emit step
   assign new_byte = repl_ff ? u8s_pkg::repl_byte(emit_k_ff) : buf_ff[0];
   assign emit_end = ({1'b0, emit_k_ff} == (emit_len_ff - 3'd1));

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      buf_in        = buf_ff;
      cnt_in        = cnt_ff;
      flush_in      = flush_ff;
      drain_in      = drain_ff;
      repl_in       = repl_ff;
      emit_len_in   = emit_len_ff;
      emit_k_in     = emit_k_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == u8s_pkg::ACT_APPEND) begin
                  buf_in[cnt_ff[1:0]] = req_data_byte;
                  cnt_in              = cnt_ff + 3'd1;
               end
               flush_in = (req_action == u8s_pkg::ACT_FLUSH);
               drain_in = 1'b0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            emit_k_in = 2'd0;
            if (cnt_ff == 3'd0) begin
               state_in = S_FINISH;
            end else if (drain_ff || lead_len == 3'd0) begin
               repl_in     = 1'b1;
               emit_len_in = u8s_pkg::REPL_LEN;
               state_in    = S_EMIT;
            end else if (lead_len > cnt_ff) begin
               // unfinished sequence: held, or all replaced on a flush
               if (flush_ff) begin
                  drain_in    = 1'b1;
                  repl_in     = 1'b1;
                  emit_len_in = u8s_pkg::REPL_LEN;
                  state_in    = S_EMIT;
               end else begin
                  state_in = S_FINISH;
               end
            end else if (!seq_good) begin
               repl_in     = 1'b1;
               emit_len_in = u8s_pkg::REPL_LEN;
               state_in    = S_EMIT;
            end else begin
               repl_in     = 1'b0;
               emit_len_in = lead_len;
               state_in    = S_EMIT;
            end
         end

         S_EMIT: begin
            if (can_push) begin
               // previous byte moves out, it is not the last one
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = pend_byte_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_byte_in  = new_byte;
               // pass-through bytes leave the window one by one
               if (!repl_ff || emit_end) begin
                  buf_in[0] = buf_ff[1];
                  buf_in[1] = buf_ff[2];
                  buf_in[2] = buf_ff[3];
                  cnt_in    = cnt_ff - 3'd1;
               end
               if (emit_end) begin
                  state_in = S_SCAN;
               end else begin
                  emit_k_in = emit_k_ff + 2'd1;
               end
            end
         end

         S_FINISH: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = pend_byte_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
               if (flush_ff) begin
                  cnt_in = 3'd0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= 3'd0;
         flush_ff      <= 1'b0;
         drain_ff      <= 1'b0;
         repl_ff       <= 1'b0;
         emit_len_ff   <= 3'd0;
         emit_k_ff     <= 2'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         flush_ff      <= flush_in;
         drain_ff      <= drain_in;
         repl_ff       <= repl_in;
         emit_len_ff   <= emit_len_in;
         emit_k_ff     <= emit_k_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      buf_ff       <= buf_in;
      pend_byte_ff <= pend_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ===== rtl/u8s_checker.sv =====
module u8s_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // after reset the block is ready and shows no word
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // an accepted item keeps the input closed for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // bytes that never occur in well-formed text never leave the block
   a_no_bad_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_out_byte == 8'hC0 || rsp_out_byte == 8'hC1 ||
                      rsp_out_byte >= 8'hF5))
      else $error("ill-formed byte on output");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                  $stable(rsp_out_last))
      else $error("stalled word changed");

endmodule

bind utf8_stream_sanitizer u8s_checker u_u8s_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);
